[hdl/ipvc_pkg.sv]
`default_nettype none

package ipvc_pkg;

    localparam int SpeedWidth = 16;
    localparam int ErrWidth   = 17;
    localparam int DeltaWidth = 18;
    localparam int GainWidth  = 16;
    localparam int LimitWidth = 13;
    localparam int DriveWidth = 14;
    localparam int SumWidth   = 36;
    localparam int FracBits   = 8;
    localparam int QuotWidth  = SumWidth - FracBits;
    localparam int Channels   = 2;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_DIFF_GAIN    = 2'd0,
        REG_ERROR_GAIN   = 2'd1,
        REG_OUTPUT_LIMIT = 2'd2
    } reg_index_t;

    localparam logic [GainWidth-1:0]  DiffGainReset    = 16'd333;
    localparam logic [GainWidth-1:0]  ErrorGainReset   = 16'd666;
    localparam logic [LimitWidth-1:0] OutputLimitReset = 13'd7000;

endpackage

`default_nettype wire

[hdl/incremental_pi_velocity_controller_core.sv]
`default_nettype none

// Two-channel incremental PI speed controller. Each input transfer carries a target and a
// measured speed on s_tdata and the motor channel on s_tuser; the block adds
// diff_gain*(error - previous error) + error_gain*error (Q8.8 gains) to that channel's
// stored drive, truncates toward zero, clamps to +/-output_limit and returns the new drive
// on m_tdata. One item is accepted every cycle unless the output stalls; each item passes
// through the input register, then the two gain multipliers, the adder and the clamp into
// the result register, where the channel state is updated too. Items on the same channel
// may follow each other back to back. Registers are written via wr_en/wr_index/wr_data
// by the user only while no item is in flight; the block itself does not enforce this.
module incremental_pi_velocity_controller_core
    import ipvc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [31:0]              s_tdata,   // target_speed, measured_speed
    input  wire logic [0:0]               s_tuser,   // channel
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [15:0]                   m_tdata,   // drive, zero pad
    input  wire logic                     wr_en,
    input  wire logic [CfgIndexWidth-1:0] wr_index,
    input  wire logic [CfgDataWidth-1:0]  wr_data
);

    logic [GainWidth-1:0]  diff_gain_reg;
    logic [GainWidth-1:0]  error_gain_reg;
    logic [LimitWidth-1:0] output_limit_reg;

    logic signed [DriveWidth-1:0] drive_store_reg [Channels];
    logic signed [ErrWidth-1:0]   last_error_reg  [Channels];

    logic                         in_valid_reg;
    logic                         in_channel_reg;
    logic signed [SpeedWidth-1:0] in_target_reg;
    logic signed [SpeedWidth-1:0] in_measured_reg;

    logic                         out_valid_reg;
    logic signed [DriveWidth-1:0] out_drive_reg;

    logic                         advance;
    logic signed [ErrWidth-1:0]   err;
    logic signed [DeltaWidth-1:0] delta;
    logic signed [SumWidth-1:0]   diff_term;
    logic signed [SumWidth-1:0]   error_term;
    logic signed [SumWidth-1:0]   base_term;
    logic signed [SumWidth-1:0]   sum;
    logic signed [QuotWidth-1:0]  quot;
    logic signed [QuotWidth-1:0]  lim_pos;
    logic signed [QuotWidth-1:0]  lim_neg;
    logic signed [DriveWidth-1:0] drive_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-DriveWidth){1'b0}}, out_drive_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_gain_reg    <= DiffGainReset;
            error_gain_reg   <= ErrorGainReset;
            output_limit_reg <= OutputLimitReset;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DIFF_GAIN:    diff_gain_reg    <= wr_data[GainWidth-1:0];
                REG_ERROR_GAIN:   error_gain_reg   <= wr_data[GainWidth-1:0];
                REG_OUTPUT_LIMIT: output_limit_reg <= wr_data[LimitWidth-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_channel_reg  <= s_tuser[0];
            in_target_reg   <= $signed(s_tdata[15:0]);
            in_measured_reg <= $signed(s_tdata[31:16]);
        end
    end

    always_comb
    begin
        err   = $signed({in_target_reg[SpeedWidth-1], in_target_reg})
              - $signed({in_measured_reg[SpeedWidth-1], in_measured_reg});
        delta = $signed({err[ErrWidth-1], err})
              - $signed({last_error_reg[in_channel_reg][ErrWidth-1],
                         last_error_reg[in_channel_reg]});
        diff_term  = SumWidth'($signed({1'b0, diff_gain_reg}) * delta);
        error_term = SumWidth'($signed({1'b0, error_gain_reg}) * err);
        base_term  = SumWidth'($signed({drive_store_reg[in_channel_reg], {FracBits{1'b0}}}));
        sum        = base_term + diff_term + error_term;
        quot       = $signed(sum[SumWidth-1:FracBits]);
        if (sum[SumWidth-1] && (|sum[FracBits-1:0]))
        begin
            quot = quot + QuotWidth'(1);
        end
        lim_pos = $signed({{(QuotWidth-LimitWidth){1'b0}}, output_limit_reg});
        lim_neg = -lim_pos;
        if (quot > lim_pos)
        begin
            drive_next = lim_pos[DriveWidth-1:0];
        end
        else if (quot < lim_neg)
        begin
            drive_next = lim_neg[DriveWidth-1:0];
        end
        else
        begin
            drive_next = quot[DriveWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < Channels; i++)
            begin
                drive_store_reg[i] <= '0;
                last_error_reg[i]  <= '0;
            end
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                drive_store_reg[in_channel_reg] <= drive_next;
                last_error_reg[in_channel_reg]  <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_drive_reg <= drive_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled while result register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted transfer lost from input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_target_reg)
                                        && $stable(in_measured_reg)))
        else $error("pending item dropped during output stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        (drive_store_reg[0] != 14'sh2000) && (drive_store_reg[1] != 14'sh2000))
        else $error("stored drive outside clamp range");

endmodule

`default_nettype wire

[verif/tb_incremental_pi_velocity_controller_core.sv]
`timescale 1ns / 1ps

module tb_incremental_pi_velocity_controller_core;
    import ipvc_pkg::*;

    localparam int CycleLimit = 200000;
    localparam logic [CfgIndexWidth-1:0] RegUnmapped = 2'd3;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [31:0]              s_tdata  = '0;
    logic [0:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [15:0]              m_tdata;
    logic                     wr_en    = 1'b0;
    logic [CfgIndexWidth-1:0] wr_index = '0;
    logic [CfgDataWidth-1:0]  wr_data  = '0;

    logic [GainWidth-1:0]  diff_gain_q  = DiffGainReset;
    logic [GainWidth-1:0]  error_gain_q = ErrorGainReset;
    logic [LimitWidth-1:0] limit_q      = OutputLimitReset;
    longint drive_mem[Channels] = '{default: 0};
    longint error_mem[Channels] = '{default: 0};

    logic [DriveWidth-1:0] pending_drive[$];
    int mismatch_count = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;

    incremental_pi_velocity_controller_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [DriveWidth-1:0] next_drive(input logic ch,
                                                         input logic signed [15:0] tgt,
                                                         input logic signed [15:0] meas);
        longint err;
        longint total;
        longint d;
        longint lim;
        err   = longint'(tgt) - longint'(meas);
        total = drive_mem[ch] * 256
              + longint'(diff_gain_q) * (err - error_mem[ch])
              + longint'(error_gain_q) * err;
        d     = total / 256;
        lim   = longint'(limit_q);
        if (d > lim)
            d = lim;
        else if (d < -lim)
            d = -lim;
        drive_mem[ch] = d;
        error_mem[ch] = err;
        return d[DriveWidth-1:0];
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(input logic ch, input logic [15:0] tgt, input logic [15:0] meas);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {meas, tgt};
        s_tuser  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        pending_drive.push_back(next_drive(ch, $signed(tgt), $signed(meas)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_DIFF_GAIN:    diff_gain_q  = data;
            REG_ERROR_GAIN:   error_gain_q = data;
            REG_OUTPUT_LIMIT: limit_q      = data[LimitWidth-1:0];
            default:          ;
        endcase
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        logic [LimitWidth-1:0] lim;
        case ($urandom_range(0, 3))
            0:       lim = '0;
            1:       lim = 13'd8191;
            default: lim = 13'($urandom_range(0, 8191));
        endcase
        return {3'($urandom), lim};
    endfunction

    task automatic send_random_item();
        logic        ch;
        logic [15:0] tgt;
        logic [15:0] meas;
        ch  = 1'($urandom_range(0, 1));
        tgt = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            meas = 16'($urandom);
        else
            meas = tgt - 16'($urandom_range(0, 400)) + 16'd200;
        send_item(ch, tgt, meas);
    endtask

    task automatic test_defaults();
        send_item(1'b0, 16'h7FFF, 16'h8000);
        send_item(1'b1, 16'h8000, 16'h7FFF);
        send_item(1'b0, 16'h0000, 16'h0000);
        send_item(1'b1, 16'h0064, 16'h0064);
        send_item(1'b0, 16'hFFFF, 16'h0001);
        send_item(1'b1, 16'h8000, 16'h8000);
        wait_drained();
    endtask

    task automatic test_register_edges();
        write_reg(RegUnmapped, 16'h1234);
        write_reg(REG_OUTPUT_LIMIT, 16'hFFFF);
        write_reg(REG_DIFF_GAIN, 16'hFFFF);
        write_reg(REG_ERROR_GAIN, 16'hFFFF);
        send_item(1'b0, 16'h7FFF, 16'h8000);
        send_item(1'b1, 16'h8000, 16'h7FFF);
        send_item(1'b0, 16'h0003, 16'h0001);
        send_item(1'b1, 16'hFFFE, 16'h0000);
        wait_drained();
        write_reg(REG_DIFF_GAIN, 16'h0000);
        write_reg(REG_ERROR_GAIN, 16'h0000);
        send_item(1'b0, 16'h7FFF, 16'h0000);
        send_item(1'b1, 16'h1234, 16'h4321);
        wait_drained();
    endtask

    task automatic test_zero_limit();
        write_reg(REG_DIFF_GAIN, DiffGainReset);
        write_reg(REG_ERROR_GAIN, ErrorGainReset);
        write_reg(REG_OUTPUT_LIMIT, 16'h0000);
        send_item(1'b0, 16'h7FFF, 16'h8000);
        send_item(1'b1, 16'h8000, 16'h7FFF);
        send_item(1'b0, 16'h0010, 16'h0000);
        wait_drained();
    endtask

    task automatic test_limit_lowered();
        write_reg(REG_DIFF_GAIN, 16'h0000);
        write_reg(REG_ERROR_GAIN, 16'hFFFF);
        write_reg(REG_OUTPUT_LIMIT, 16'd8191);
        send_item(1'b0, 16'd1000, 16'd0);
        send_item(1'b1, 16'd0, 16'd1000);
        wait_drained();
        write_reg(REG_OUTPUT_LIMIT, 16'd100);
        send_item(1'b1, 16'd5, 16'd5);
        send_item(1'b0, 16'd5, 16'd5);
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 60;
        repeat (30) send_random_item();
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_DIFF_GAIN, pick_gain());
            write_reg(REG_ERROR_GAIN, pick_gain());
            write_reg(REG_OUTPUT_LIMIT, pick_limit());
            tx_idle = (phase % 3) != 1;
            rx_idle = (phase % 2) == 0;
            repeat (100) send_random_item();
            wait_drained();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin : result_check
        logic [DriveWidth-1:0] want;
        int rx_gap;
        rx_gap = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_drive.size() == 0)
                begin
                    report($sformatf("unexpected drive %0d", $signed(m_tdata[DriveWidth-1:0])));
                end
                else
                begin
                    want = pending_drive.pop_front();
                    if (m_tdata[DriveWidth-1:0] !== want)
                        report($sformatf("drive got %0d want %0d",
                                         $signed(m_tdata[DriveWidth-1:0]), $signed(want)));
                end
                rx_gap = rx_idle ? $urandom_range(0, 8) : 0;
            end
            if (!rst_n)
            begin
                m_tready <= 1'b0;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL incremental_pi_velocity_controller_core");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_register_edges();
        test_zero_limit();
        test_limit_lowered();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_drive.size() != 0)
            report($sformatf("%0d drive values never arrived", pending_drive.size()));
        if (mismatch_count == 0)
            $display("PASS incremental_pi_velocity_controller_core");
        else
            $display("FAIL incremental_pi_velocity_controller_core");
        $finish;
    end

endmodule
